// File: src/updc_pkg.sv
package updc_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_NUL     = 8'h00;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_esc_phase;

    typedef enum logic [1:0] {
        KIND_EMPTY  = 2'd0,
        KIND_DOT    = 2'd1,
        KIND_DOTDOT = 2'd2,
        KIND_OTHER  = 2'd3
    } t_comp_kind;

    typedef enum logic [2:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_SLASH     = 3'd1,
        CAUSE_ESCAPE    = 3'd2,
        CAUSE_NUL       = 3'd3,
        CAUSE_COMPONENT = 3'd4
    } t_cause;

    typedef struct packed {
        logic [7:0] decoded_byte;
        logic       out_byte_valid;
        logic       path_done;
        logic       path_ok;
        t_cause     reject_cause;
    } t_result;

    // hex digit of either case; valid=0 for anything else
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

// File: src/url_path_decode_and_check.sv
// Channel  | Dir | tdata (low bit up)                         | tuser          | tlast
// ---------+-----+--------------------------------------------+----------------+----------
// s_axis   | in  | raw_byte[7:0]                              | byte_present   | last_item
// m_axis   | out | decoded_byte[7:0], path_ok, reject_cause[2:0], 4'b0 | out_byte_valid | path_done
//
// One request per cycle, sustained while m_axis takes results. Decode and path checks
// are a single level of logic between the decoder state registers and the output register.
// A skid register behind the output register keeps s_axis_tready registered;
// it drops only while both hold results that m_axis has not taken.
// Synchronous active-low reset clears decoder state and the valid flags of both output slots.
// A request with no result (no byte, escape in progress, not last) is consumed silently.
module url_path_decode_and_check
    import updc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // raw_byte[7:0]
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // last_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // decoded_byte[7:0], path_ok, reject_cause[2:0], zeros
    output logic        m_axis_tuser,   // out_byte_valid
    output logic        m_axis_tlast    // path_done
);

    t_esc_phase r_esc_phase, n_esc_phase;
    logic [3:0] r_high_nib, n_high_nib;
    logic       r_first, n_first;
    t_comp_kind r_kind, n_kind;
    logic       r_slash_err, n_slash_err;
    logic       r_esc_err, n_esc_err;
    logic       r_nul_err, n_nul_err;
    logic       r_comp_err, n_comp_err;

    t_result    r_out, r_skid, n_res;
    logic       r_out_valid, r_skid_valid;
    logic       n_res_valid;

    logic       in_fire;
    logic       out_fire;
    logic [4:0] hex;
    logic       take;
    logic [7:0] dbyte;

    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = r_out_valid && m_axis_tready;
    assign hex           = hex_digit(s_axis_tdata);

    always_comb begin
        n_esc_phase = r_esc_phase;
        n_high_nib  = r_high_nib;
        n_first     = r_first;
        n_kind      = r_kind;
        n_slash_err = r_slash_err;
        n_esc_err   = r_esc_err;
        n_nul_err   = r_nul_err;
        n_comp_err  = r_comp_err;
        take        = 1'b0;
        dbyte       = s_axis_tdata;
        n_res       = '0;
        n_res_valid = 1'b0;

        if (s_axis_tuser) begin
            if (r_first && s_axis_tdata == CH_SLASH) begin
                n_slash_err = 1'b1;
            end
            n_first = 1'b0;
            case (r_esc_phase)
                ESC_HIGH: begin
                    if (!hex[4]) begin
                        if (!(r_esc_err || r_nul_err)) n_esc_err = 1'b1;
                        n_esc_phase = ESC_NONE;
                    end else begin
                        n_high_nib  = hex[3:0];
                        n_esc_phase = ESC_LOW;
                    end
                end
                ESC_LOW: begin
                    n_esc_phase = ESC_NONE;
                    dbyte       = {r_high_nib, hex[3:0]};
                    if (!hex[4]) begin
                        if (!(r_esc_err || r_nul_err)) n_esc_err = 1'b1;
                    end else if (dbyte == CH_NUL) begin
                        if (!(r_esc_err || r_nul_err)) n_nul_err = 1'b1;
                    end else begin
                        take = 1'b1;
                    end
                end
                default: begin
                    if (s_axis_tdata == CH_PERCENT) begin
                        n_esc_phase = ESC_HIGH;
                    end else begin
                        take = 1'b1;
                    end
                end
            endcase
        end

        // component tracking on each decoded byte
        if (take) begin
            if (dbyte == CH_SLASH) begin
                if (r_kind != KIND_OTHER) n_comp_err = 1'b1;
                n_kind = KIND_EMPTY;
            end else begin
                if (dbyte == CH_NUL) n_comp_err = 1'b1;
                if (dbyte == CH_DOT && r_kind == KIND_EMPTY) begin
                    n_kind = KIND_DOT;
                end else if (dbyte == CH_DOT && r_kind == KIND_DOT) begin
                    n_kind = KIND_DOTDOT;
                end else begin
                    n_kind = KIND_OTHER;
                end
            end
            n_res.decoded_byte   = dbyte;
            n_res.out_byte_valid = 1'b1;
            n_res_valid          = 1'b1;
        end

        if (s_axis_tlast) begin
            if (n_esc_phase != ESC_NONE && !(n_esc_err || n_nul_err)) n_esc_err = 1'b1;
            if (n_kind == KIND_DOT || n_kind == KIND_DOTDOT) n_comp_err = 1'b1;
            n_res.path_done = 1'b1;
            if (n_slash_err) begin
                n_res.reject_cause = CAUSE_SLASH;
            end else if (n_esc_err) begin
                n_res.reject_cause = CAUSE_ESCAPE;
            end else if (n_nul_err) begin
                n_res.reject_cause = CAUSE_NUL;
            end else if (n_comp_err) begin
                n_res.reject_cause = CAUSE_COMPONENT;
            end else begin
                n_res.reject_cause = CAUSE_NONE;
            end
            n_res.path_ok = (n_res.reject_cause == CAUSE_NONE);
            n_res_valid   = 1'b1;
            // back to the start-of-path state
            n_esc_phase = ESC_NONE;
            n_high_nib  = 4'd0;
            n_first     = 1'b1;
            n_kind      = KIND_EMPTY;
            n_slash_err = 1'b0;
            n_esc_err   = 1'b0;
            n_nul_err   = 1'b0;
            n_comp_err  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_phase <= ESC_NONE;
            r_high_nib  <= 4'd0;
            r_first     <= 1'b1;
            r_kind      <= KIND_EMPTY;
            r_slash_err <= 1'b0;
            r_esc_err   <= 1'b0;
            r_nul_err   <= 1'b0;
            r_comp_err  <= 1'b0;
        end else if (in_fire) begin
            r_esc_phase <= n_esc_phase;
            r_high_nib  <= n_high_nib;
            r_first     <= n_first;
            r_kind      <= n_kind;
            r_slash_err <= n_slash_err;
            r_esc_err   <= n_esc_err;
            r_nul_err   <= n_nul_err;
            r_comp_err  <= n_comp_err;
        end
    end

    // output register with skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire && n_res_valid;
            end
        end else if (in_fire && n_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= n_res;
            end
        end else if (in_fire && n_res_valid) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.reject_cause, r_out.path_ok, r_out.decoded_byte};
    assign m_axis_tuser  = r_out.out_byte_valid;
    assign m_axis_tlast  = r_out.path_done;

endmodule

// File: tb/url_path_decode_and_check_checker.sv
module url_path_decode_and_check_checker
    import updc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // raw_byte[7:0]
    input  logic        s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,   // last_item
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // decoded_byte[7:0], path_ok, reject_cause[2:0], zeros
    input  logic        m_axis_tuser,   // out_byte_valid
    input  logic        m_axis_tlast,   // path_done
    output int          o_err_count,
    output int          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    t_result    expected_decodes[$];

    // shadow of the decoder state for the path in flight
    t_esc_phase esc_phase;
    logic [3:0] hi_nib;
    logic       first_byte;
    t_comp_kind comp_kind;
    logic       lead_slash_err;
    logic       esc_err;
    logic       nul_err;
    logic       comp_err;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    task automatic clear_path_state();
        esc_phase      = ESC_NONE;
        hi_nib         = 4'h0;
        first_byte     = 1'b1;
        comp_kind      = KIND_EMPTY;
        lead_slash_err = 1'b0;
        esc_err        = 1'b0;
        nul_err        = 1'b0;
        comp_err       = 1'b0;
    endtask

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    // only the first escape-class fault of a path is kept
    task automatic note_escape_fault(input logic is_nul);
        if (!(esc_err || nul_err)) begin
            if (is_nul) nul_err = 1'b1;
            else esc_err = 1'b1;
        end
    endtask

    task automatic track_component(input logic [7:0] d);
        if (d == CH_SLASH) begin
            if (comp_kind != KIND_OTHER) comp_err = 1'b1;
            comp_kind = KIND_EMPTY;
        end else begin
            if (d == CH_NUL) comp_err = 1'b1;
            if (d == CH_DOT && comp_kind == KIND_EMPTY) comp_kind = KIND_DOT;
            else if (d == CH_DOT && comp_kind == KIND_DOT) comp_kind = KIND_DOTDOT;
            else comp_kind = KIND_OTHER;
        end
    endtask

    task automatic decode_raw_byte(input logic [7:0] rb, input logic present, input logic last);
        t_result    r;
        t_cause     cause;
        logic       emit;
        logic [7:0] ob;
        int         nib;
        emit = 1'b0;
        ob   = 8'h00;
        if (present) begin
            if (first_byte && rb == CH_SLASH) lead_slash_err = 1'b1;
            first_byte = 1'b0;
            case (esc_phase)
                ESC_HIGH: begin
                    nib = hex_nibble(rb);
                    if (nib < 0) begin
                        note_escape_fault(1'b0);
                        esc_phase = ESC_NONE;
                    end else begin
                        hi_nib    = nib[3:0];
                        esc_phase = ESC_LOW;
                    end
                end
                ESC_LOW: begin
                    nib       = hex_nibble(rb);
                    esc_phase = ESC_NONE;
                    if (nib < 0) begin
                        note_escape_fault(1'b0);
                    end else if ({hi_nib, nib[3:0]} == CH_NUL) begin
                        note_escape_fault(1'b1);
                    end else begin
                        ob   = {hi_nib, nib[3:0]};
                        emit = 1'b1;
                        track_component(ob);
                    end
                end
                default: begin
                    if (rb == CH_PERCENT) begin
                        esc_phase = ESC_HIGH;
                    end else begin
                        ob   = rb;
                        emit = 1'b1;
                        track_component(ob);
                    end
                end
            endcase
        end

        r.decoded_byte   = ob;
        r.out_byte_valid = emit;
        r.path_done      = 1'b0;
        r.path_ok        = 1'b0;
        r.reject_cause   = CAUSE_NONE;

        if (last) begin
            // an escape cut off by the end of the path is a bad escape
            if (esc_phase != ESC_NONE) note_escape_fault(1'b0);
            if (comp_kind == KIND_DOT || comp_kind == KIND_DOTDOT) comp_err = 1'b1;
            if (lead_slash_err) cause = CAUSE_SLASH;
            else if (esc_err) cause = CAUSE_ESCAPE;
            else if (nul_err) cause = CAUSE_NUL;
            else if (comp_err) cause = CAUSE_COMPONENT;
            else cause = CAUSE_NONE;
            r.path_done    = 1'b1;
            r.path_ok      = (cause == CAUSE_NONE);
            r.reject_cause = cause;
            expected_decodes = {expected_decodes, r};
            clear_path_state();
        end else if (emit) begin
            expected_decodes = {expected_decodes, r};
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            o_err_count = o_err_count + 1;
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            clear_path_state();
            expected_decodes.delete();
        end else begin
            // output side first: a result cannot stem from a request taken at this edge
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_decodes.size() == 0) begin
                    o_err_count = o_err_count + 1;
                    $display("%0t: unexpected result: expected none, actual tdata=%h user=%b last=%b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = expected_decodes.pop_front();
                    check_field("decoded_byte", want.decoded_byte, m_axis_tdata[7:0]);
                    check_field("out_byte_valid", want.out_byte_valid, m_axis_tuser);
                    check_field("path_done", want.path_done, m_axis_tlast);
                    check_field("path_ok", want.path_ok, m_axis_tdata[8]);
                    check_field("reject_cause", want.reject_cause, m_axis_tdata[11:9]);
                    check_field("tdata padding", 0, m_axis_tdata[15:12]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_raw_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            end
        end
        o_pending = expected_decodes.size();
    end

endmodule

// File: tb/url_path_decode_and_check_tb.sv
module url_path_decode_and_check_tb
    import updc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_PASS = 175;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int          err_count;
    int          pending_count;
    int          cycle_count   = 0;
    int          items_sent    = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [7:0]  path_bytes[$];

    url_path_decode_and_check dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    url_path_decode_and_check_checker u_path_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_err_count   (err_count),
        .o_pending     (pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(input logic [7:0] b, input logic present, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (present || last) items_sent++;
    endtask

    // send the queued bytes as one path, with the odd empty request mixed in
    task automatic flush_path();
        int n;
        n = path_bytes.size();
        if (n == 0) begin
            send_request(8'($urandom), 1'b0, 1'b1);
        end else begin
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 15) == 0) send_request(8'($urandom), 1'b0, 1'b0);
                send_request(path_bytes[i], 1'b1, i == n - 1);
            end
        end
        path_bytes.delete();
    endtask

    task automatic add_byte(input logic [7:0] b);
        path_bytes = {path_bytes, b};
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 10) return 8'h30 + n;
        return 8'((upper ? 8'h41 : 8'h61) + n - 10);
    endfunction

    task automatic push_escape(input logic [7:0] d);
        add_byte(CH_PERCENT);
        add_byte(hex_char(d[7:4], 1'($urandom_range(0, 1))));
        add_byte(hex_char(d[3:0], 1'($urandom_range(0, 1))));
    endtask

    function automatic logic [7:0] plain_char();
        case ($urandom_range(0, 4))
            0: return 8'(8'h61 + $urandom_range(0, 25));
            1: return 8'(8'h41 + $urandom_range(0, 25));
            2: return 8'(8'h30 + $urandom_range(0, 9));
            3: return 8'h2D;
            default: return ($urandom_range(0, 1) != 0) ? 8'h5F : 8'h7E;
        endcase
    endfunction

    task automatic build_path(input bit well_formed);
        int ncomp;
        int len;
        int sel;
        if (well_formed) begin
            ncomp = $urandom_range(0, 4);
            for (int c = 0; c < ncomp; c++) begin
                if (c > 0) add_byte(CH_SLASH);
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    sel = $urandom_range(0, 9);
                    if (sel <= 5) add_byte(plain_char());
                    else if (sel == 6) add_byte(CH_DOT);
                    else if (sel <= 8) push_escape(8'($urandom_range(1, 255)));
                    else push_escape(plain_char());
                end
            end
            if (ncomp > 0 && $urandom_range(0, 5) == 0) add_byte(CH_SLASH);
        end else begin
            len = $urandom_range(0, 8);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 5))
                    0: add_byte(CH_PERCENT);
                    1: add_byte(CH_SLASH);
                    2: add_byte(CH_DOT);
                    3: add_byte(CH_NUL);
                    4: add_byte(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
                    default: add_byte(8'($urandom));
                endcase
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed paths
        send_request(8'h00, 1'b0, 1'b1);        // empty path
        load_text("/");                         // leading slash
        flush_path();
        load_text("a%2fZ");                     // escaped slash splits, accepted
        flush_path();
        load_text("%Ag");                       // bad low digit
        flush_path();
        load_text("%00");                       // decoded NUL
        flush_path();
        load_text("..");
        flush_path();
        load_text("x/");                        // trailing slash is fine
        flush_path();
        load_text("%z%4");                      // bad high digit, then escape cut off
        flush_path();
        send_request(CH_NUL, 1'b1, 1'b0);       // raw NUL, gap, top byte
        send_request(8'hA5, 1'b0, 1'b0);
        send_request(8'hFF, 1'b1, 1'b1);

        for (int pass = 0; pass < 3; pass++) begin
            case (pass)
                0: begin
                    send_idle_pct <= 14;
                    recv_idle_pct <= 51;
                end
                1: begin
                    send_idle_pct <= 51;
                    recv_idle_pct <= 14;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            while (items_sent < 24 + ITEMS_PER_PASS * (pass + 1)) begin
                build_path($urandom_range(0, 9) < 7);
                flush_path();
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
